/* hw/rtl/rcms_pkg.sv */
// Shared types and constants of the region color match signature block.
// Used by every module under hw/rtl; depends on nothing.
package rcms_pkg;

  localparam int DEF_FRAME_WIDTH  = 960;
  localparam int DEF_FRAME_HEIGHT = 160;

  localparam int PIX_W     = 24;
  localparam int CHAN_W    = 8;
  localparam int SUM_W     = 10;
  localparam int SIG_W     = 16;
  localparam int CNT_W     = 18;
  localparam int CHK_W     = 13;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CHAN_W-1:0] CHAN_MAX  = CHAN_W'(255);
  localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(255 * 3);

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RED   = 3'd0,
    REG_MAX_RED   = 3'd1,
    REG_MIN_GREEN = 3'd2,
    REG_MAX_GREEN = 3'd3,
    REG_MIN_BLUE  = 3'd4,
    REG_MAX_BLUE  = 3'd5,
    REG_MIN_SUM   = 3'd6,
    REG_MAX_SUM   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_WRITE,
    ST_READ,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [9:0]  pos_x;
    logic [7:0]  pos_y;
    logic [9:0]  region_width;
    logic [7:0]  region_height;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [SIG_W-1:0]  signature;
    logic [CNT_W-1:0]  match_count;
    logic [CNT_W-1:0]  pixel_total;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic [SUM_W-1:0]  channel_sum;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic calc_addr;
    logic wr_item;
    logic rd_issue;
    logic walk_step;
    logic clr_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t in_mode;
    logic  in_inside;
    logic  in_region_ok;
    mode_t item_mode;
    logic  clr_last;
    logic  walk_last;
  } dp_stat_t;

endpackage

/* hw/rtl/rcms_frame_ram.sv */
// Single-port-write, single-port-read frame memory with registered read data.
// Depends on rcms_pkg for the pixel width.
module rcms_frame_ram import rcms_pkg::*; #(
  parameter int DEPTH  = DEF_FRAME_WIDTH * DEF_FRAME_HEIGHT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/rcms_ctrl.sv */
// Controller state machine: sequences clearing, writes, reads and region walks.
// Depends on rcms_pkg for the state, command and status types.
module rcms_ctrl import rcms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (stat.in_mode)
            MODE_WRITE: state_nxt = stat.in_inside ? ST_ADDR : ST_IDLE;
            MODE_READ:  state_nxt = stat.in_inside ? ST_ADDR : ST_DONE;
            MODE_QUERY: state_nxt = stat.in_region_ok ? ST_ADDR : ST_DONE;
            MODE_NONE:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADDR: begin
        cmd.calc_addr = 1'b1;
        unique case (stat.item_mode)
          MODE_WRITE: state_nxt = ST_WRITE;
          MODE_READ:  state_nxt = ST_READ;
          MODE_QUERY: state_nxt = ST_WALK;
          MODE_NONE:  state_nxt = ST_IDLE;
        endcase
      end
      ST_WRITE: begin
        cmd.wr_item = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/rcms_dp.sv */
// Datapath: item and bound registers, address generation, region walk,
// match test and signature accumulation. Depends on rcms_pkg and rcms_frame_ram.
module rcms_dp import rcms_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  output out_item_t            out_data
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  logic [CHAN_W-1:0] min_red_r, max_red_r, min_green_r, max_green_r;
  logic [CHAN_W-1:0] min_blue_r, max_blue_r;
  logic [SUM_W-1:0]  min_sum_r, max_sum_r;

  in_item_t          item_r;
  logic              err_r;
  logic [ADDR_W-1:0] addr_r, stride_r, clr_cnt_r;
  logic [COL_W-1:0]  col_r, start_col_r, end_col_r, ev_col_r;
  logic [ROW_W-1:0]  row_r, end_row_r, ev_row_r;
  logic              ev_valid_r;
  logic [SIG_W-1:0]  sig_r, sig_nxt;
  logic [CNT_W-1:0]  match_r, total_r;
  out_item_t         out_data_r, out_data_nxt;

  logic [CHK_W-1:0]  px_c, py_c, rw_c, rh_c;
  logic              in_inside, in_region_ok;
  logic [PIX_W-1:0]  rd_data;
  logic [CHAN_W-1:0] pix_r, pix_g, pix_b;
  logic [SUM_W-1:0]  pix_sum;
  logic              pix_match;
  logic [SIG_W-1:0]  sig_rot, pos_term;
  logic              walk_row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_red_r   <= '0;
      max_red_r   <= CHAN_MAX;
      min_green_r <= '0;
      max_green_r <= CHAN_MAX;
      min_blue_r  <= '0;
      max_blue_r  <= CHAN_MAX;
      min_sum_r   <= '0;
      max_sum_r   <= SUM_MAX;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_RED:   min_red_r   <= cfg_wdata[CHAN_W-1:0];
        REG_MAX_RED:   max_red_r   <= cfg_wdata[CHAN_W-1:0];
        REG_MIN_GREEN: min_green_r <= cfg_wdata[CHAN_W-1:0];
        REG_MAX_GREEN: max_green_r <= cfg_wdata[CHAN_W-1:0];
        REG_MIN_BLUE:  min_blue_r  <= cfg_wdata[CHAN_W-1:0];
        REG_MAX_BLUE:  max_blue_r  <= cfg_wdata[CHAN_W-1:0];
        REG_MIN_SUM:   min_sum_r   <= cfg_wdata[SUM_W-1:0];
        REG_MAX_SUM:   max_sum_r   <= cfg_wdata[SUM_W-1:0];
      endcase
    end
  end

  assign px_c = CHK_W'(in_data.pos_x);
  assign py_c = CHK_W'(in_data.pos_y);
  assign rw_c = CHK_W'(in_data.region_width);
  assign rh_c = CHK_W'(in_data.region_height);

  assign in_inside    = (px_c < CHK_W'(FRAME_WIDTH)) && (py_c < CHK_W'(FRAME_HEIGHT));
  assign in_region_ok = in_inside && (rw_c != '0) && (rh_c != '0) &&
                        (px_c + rw_c <= CHK_W'(FRAME_WIDTH)) &&
                        (py_c + rh_c <= CHK_W'(FRAME_HEIGHT));

  assign walk_row_end = (col_r == end_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      ev_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      ev_valid_r <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_data;
      err_r       <= ((in_data.mode == MODE_READ) && !in_inside) ||
                     ((in_data.mode == MODE_QUERY) && !in_region_ok);
      col_r       <= COL_W'(in_data.pos_x);
      start_col_r <= COL_W'(in_data.pos_x);
      row_r       <= ROW_W'(in_data.pos_y);
      end_col_r   <= COL_W'(px_c + rw_c - CHK_W'(1));
      end_row_r   <= ROW_W'(py_c + rh_c - CHK_W'(1));
      stride_r    <= ADDR_W'(32'(FRAME_WIDTH) - 32'(in_data.region_width) + 32'd1);
    end else if (cmd.walk_step) begin
      if (walk_row_end) begin
        col_r <= start_col_r;
        row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
    if (cmd.calc_addr) begin
      addr_r <= ADDR_W'(32'(item_r.pos_y) * 32'(FRAME_WIDTH) + 32'(item_r.pos_x));
    end else if (cmd.walk_step) begin
      addr_r <= walk_row_end ? addr_r + stride_r : addr_r + ADDR_W'(1);
    end
    ev_col_r <= col_r;
    ev_row_r <= row_r;
  end

  rcms_frame_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (cmd.clr_step | cmd.wr_item),
    .waddr (cmd.clr_step ? clr_cnt_r : addr_r),
    .wdata (cmd.clr_step ? '0 : {item_r.red_in, item_r.green_in, item_r.blue_in}),
    .re    (cmd.rd_issue | cmd.walk_step),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  assign pix_r   = rd_data[23:16];
  assign pix_g   = rd_data[15:8];
  assign pix_b   = rd_data[7:0];
  assign pix_sum = SUM_W'(pix_r) + SUM_W'(pix_g) + SUM_W'(pix_b);

  assign pix_match = (pix_sum >= min_sum_r) && (pix_sum <= max_sum_r) &&
                     (pix_r >= min_red_r) && (pix_r <= max_red_r) &&
                     (pix_g >= min_green_r) && (pix_g <= max_green_r) &&
                     (pix_b >= min_blue_r) && (pix_b <= max_blue_r);

  assign sig_rot  = {sig_r[SIG_W-2:0], sig_r[SIG_W-1]};
  assign pos_term = SIG_W'((32'(ev_col_r) << 8) + 32'(ev_row_r));
  assign sig_nxt  = pix_match ? sig_rot + pos_term : sig_rot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sig_r   <= '0;
      match_r <= '0;
      total_r <= '0;
    end else if (ev_valid_r) begin
      sig_r   <= sig_nxt;
      total_r <= total_r + CNT_W'(1);
      if (pix_match) begin
        match_r <= match_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (err_r) begin
      out_data_nxt.status = 1'b1;
    end else if (item_r.mode == MODE_READ) begin
      out_data_nxt.red_out     = pix_r;
      out_data_nxt.green_out   = pix_g;
      out_data_nxt.blue_out    = pix_b;
      out_data_nxt.channel_sum = pix_sum;
    end else begin
      out_data_nxt.signature   = sig_r;
      out_data_nxt.match_count = match_r;
      out_data_nxt.pixel_total = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_data = out_data_r;

  assign stat.in_mode      = in_data.mode;
  assign stat.in_inside    = in_inside;
  assign stat.in_region_ok = in_region_ok;
  assign stat.item_mode    = item_r.mode;
  assign stat.clr_last     = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign stat.walk_last    = walk_row_end && (row_r == end_row_r);

endmodule

/* hw/rtl/region_color_match_signature.sv */
// Top level of the region color match signature block: controller and datapath.
// Depends on rcms_pkg, rcms_ctrl, rcms_dp and rcms_frame_ram.
//
//   Channel   Signals                          Direction
//   in        in_valid, in_ready, in_data      item in (write, read, region query)
//   out       out_valid, out_ready, out_data   result out (read and query only)
//   cfg       cfg_we, cfg_index, cfg_wdata     bound register writes, no wait
//
// After reset the frame memory is cleared one pixel per cycle; in_ready stays low
// during that pass. A write passes the ADDR and WRITE states, a read the ADDR, READ
// and DONE states, and a region query ADDR, WALK, DRAIN and DONE, the walk paced by the
// single memory read port visiting one pixel per cycle.
// A new item is accepted while the previous result waits in the output register;
// a finished result then waits until that register is free.
module region_color_match_signature import rcms_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rcms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rcms_dp #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ready)
    else $error("Input ready during the frame clearing pass.");

  a_no_accept_while_walking: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> !in_ready)
    else $error("Input ready during a region walk.");

  a_walk_stops_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_step && stat.walk_last) |=> !cmd.walk_step)
    else $error("Region walk continued past its last pixel.");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("Loaded result transaction is not presented.");

endmodule

/* dv/region_color_match_signature_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for region_color_match_signature: pixel writes, reads and region queries
// checked against a shadow frame and bound registers kept here. Depends on rcms_pkg and the RTL.
module region_color_match_signature_tb;
  import rcms_pkg::*;

  localparam int          FRAME_W     = DEF_FRAME_WIDTH;
  localparam int          FRAME_H     = DEF_FRAME_HEIGHT;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          SETTLE      = 8;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bit [23:0]   frame_shadow [FRAME_W*FRAME_H];
  bit [9:0]    bound_shadow [8];
  out_item_t   pending_results [$];
  out_item_t   oldest_result;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;
  int unsigned cycle_count = 0;
  int          mismatch_count = 0;

  region_color_match_signature u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("region_color_match_signature_tb failed");
    $finish;
  end

  function automatic bit pixel_in_bounds(bit [23:0] pix);
    bit [9:0] total;
    total = 10'(pix[23:16]) + 10'(pix[15:8]) + 10'(pix[7:0]);
    return pix[23:16] >= bound_shadow[REG_MIN_RED]   && pix[23:16] <= bound_shadow[REG_MAX_RED] &&
           pix[15:8]  >= bound_shadow[REG_MIN_GREEN] && pix[15:8]  <= bound_shadow[REG_MAX_GREEN] &&
           pix[7:0]   >= bound_shadow[REG_MIN_BLUE]  && pix[7:0]   <= bound_shadow[REG_MAX_BLUE] &&
           total      >= bound_shadow[REG_MIN_SUM]   && total      <= bound_shadow[REG_MAX_SUM];
  endfunction

  // Applies one accepted transaction to the shadow frame and returns the result it causes.
  task automatic compute_expected_result(input in_item_t it, output bit produces,
                                         output out_item_t res);
    bit        inside_frame;
    bit [23:0] pix;
    bit [15:0] sig;
    bit [17:0] hits;
    bit [17:0] visited;
    res = '0;
    produces = 1'b0;
    inside_frame = it.pos_x < FRAME_W && it.pos_y < FRAME_H;
    case (it.mode)
      MODE_WRITE: begin
        if (inside_frame) begin
          frame_shadow[it.pos_y * FRAME_W + it.pos_x] = {it.red_in, it.green_in, it.blue_in};
        end
      end
      MODE_READ: begin
        produces = 1'b1;
        if (!inside_frame) begin
          res.status = 1'b1;
        end else begin
          pix = frame_shadow[it.pos_y * FRAME_W + it.pos_x];
          res.red_out = pix[23:16];
          res.green_out = pix[15:8];
          res.blue_out = pix[7:0];
          res.channel_sum = 10'(pix[23:16]) + 10'(pix[15:8]) + 10'(pix[7:0]);
        end
      end
      MODE_QUERY: begin
        produces = 1'b1;
        if (!inside_frame || it.region_width == 0 || it.region_height == 0 ||
            it.pos_x + it.region_width > FRAME_W || it.pos_y + it.region_height > FRAME_H) begin
          res.status = 1'b1;
        end else begin
          sig = '0;
          hits = '0;
          visited = '0;
          for (int row = it.pos_y; row < it.pos_y + it.region_height; row++) begin
            for (int col = it.pos_x; col < it.pos_x + it.region_width; col++) begin
              sig = {sig[14:0], sig[15]};
              visited++;
              if (pixel_in_bounds(frame_shadow[row * FRAME_W + col])) begin
                hits++;
                sig = sig + {col[7:0], row[7:0]};
              end
            end
          end
          res.signature = sig;
          res.match_count = hits;
          res.pixel_total = visited;
        end
      end
      default: ;
    endcase
  endtask

  function automatic string result_text(out_item_t r);
    return $sformatf("status=%0d sig=%04h matches=%0d total=%0d rgb=%02h%02h%02h sum=%0d",
                     r.status, r.signature, r.match_count, r.pixel_total,
                     r.red_out, r.green_out, r.blue_out, r.channel_sum);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: %s", result_text(out_data));
        end
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data !== oldest_result) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected %s", result_text(oldest_result));
            $display("                 actual   %s", result_text(out_data));
          end
        end
      end
    end
    out_ready <= rx_hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
  end

  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  task automatic send_item(input in_item_t it);
    bit        produces;
    out_item_t res;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    compute_expected_result(it, produces, res);
    if (produces) begin
      pending_results.push_back(res);
    end
  endtask

  task automatic send_write(input bit [9:0] x, input bit [7:0] y, input bit [23:0] rgb);
    in_item_t it;
    it = '0;
    it.mode = MODE_WRITE;
    it.pos_x = x;
    it.pos_y = y;
    {it.red_in, it.green_in, it.blue_in} = rgb;
    send_item(it);
  endtask

  task automatic send_read(input bit [9:0] x, input bit [7:0] y);
    in_item_t it;
    it = '0;
    it.mode = MODE_READ;
    it.pos_x = x;
    it.pos_y = y;
    send_item(it);
  endtask

  task automatic send_query(input bit [9:0] x, input bit [7:0] y,
                            input bit [9:0] w, input bit [7:0] h);
    in_item_t it;
    it = '0;
    it.mode = MODE_QUERY;
    it.pos_x = x;
    it.pos_y = y;
    it.region_width = w;
    it.region_height = h;
    send_item(it);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_bounds(input bit [7:0] r_lo, r_hi, g_lo, g_hi, b_lo, b_hi,
                            input bit [9:0] s_lo, s_hi);
    bit [9:0] vals [8];
    cfg_reg_t reg_id;
    wait_results_drained();
    vals[REG_MIN_RED] = 10'(r_lo);
    vals[REG_MAX_RED] = 10'(r_hi);
    vals[REG_MIN_GREEN] = 10'(g_lo);
    vals[REG_MAX_GREEN] = 10'(g_hi);
    vals[REG_MIN_BLUE] = 10'(b_lo);
    vals[REG_MAX_BLUE] = 10'(b_hi);
    vals[REG_MIN_SUM] = s_lo;
    vals[REG_MAX_SUM] = s_hi;
    reg_id = reg_id.first();
    do begin
      cfg_we <= 1'b1;
      cfg_index <= reg_id;
      cfg_wdata <= vals[reg_id];
      bound_shadow[reg_id] = vals[reg_id];
      @(posedge clk);
      reg_id = reg_id.next();
    end while (reg_id != reg_id.first());
    cfg_we <= 1'b0;
  endtask

  function automatic bit [7:0] pick_channel();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom());
    endcase
  endfunction

  // Mostly well-formed traffic in the four frame corners, so that queries see written pixels;
  // the rest is raw noise over every field, with huge legal regions turned into bad ones.
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [63:0] raw;
    int unsigned pick;
    int unsigned span_x;
    int unsigned span_y;
    raw = {$urandom(), $urandom()};
    it = in_item_t'(raw[$bits(in_item_t)-1:0]);
    pick = $urandom_range(99);
    if (pick < 85) begin
      it.pos_x = $urandom_range(1) ? 10'(FRAME_W - 16 + $urandom_range(15)) : 10'($urandom_range(15));
      it.pos_y = $urandom_range(1) ? 8'(FRAME_H - 4 + $urandom_range(3)) : 8'($urandom_range(3));
      it.red_in = pick_channel();
      it.green_in = pick_channel();
      it.blue_in = pick_channel();
      span_x = FRAME_W - it.pos_x;
      span_y = FRAME_H - it.pos_y;
      if (pick < 40) begin
        it.mode = MODE_WRITE;
      end else if (pick < 60) begin
        it.mode = MODE_READ;
      end else begin
        it.mode = MODE_QUERY;
        if ($urandom_range(24) == 0) begin
          it.region_width = 10'($urandom_range(1, span_x));
          it.region_height = 8'($urandom_range(1, span_y < 2 ? span_y : 2));
        end else begin
          it.region_width = 10'($urandom_range(1, span_x < 16 ? span_x : 16));
          it.region_height = 8'($urandom_range(1, span_y < 6 ? span_y : 6));
        end
      end
    end else if (it.mode == MODE_QUERY && it.region_width * it.region_height > 4096) begin
      it.region_height = 8'hff;
    end
    return it;
  endfunction

  task automatic test_cleared_frame();
    send_read(0, 0);
    send_read(FRAME_W - 1, FRAME_H - 1);
    send_query(0, 0, 4, 2);
  endtask

  task automatic test_pixel_write_read();
    in_item_t it;
    send_write(0, 0, 24'hffffff);
    send_write(FRAME_W - 1, FRAME_H - 1, 24'h01807f);
    send_write(FRAME_W - 1, 0, 24'ha55a3c);
    send_read(0, 0);
    send_read(FRAME_W - 1, FRAME_H - 1);
    send_read(FRAME_W - 1, 0);
    // A write just past the right edge must not land on the first pixel of the next row.
    send_write(FRAME_W, 0, 24'h123456);
    send_read(0, 1);
    send_read(FRAME_W, 0);
    send_read(0, FRAME_H);
    send_read(10'h3ff, 8'hff);
    it = '0;
    it.mode = MODE_NONE;
    {it.red_in, it.green_in, it.blue_in} = 24'h123456;
    send_item(it);
    send_read(0, 0);
  endtask

  task automatic test_region_geometry();
    send_query(FRAME_W - 1, FRAME_H - 1, 1, 1);
    send_query(0, 0, FRAME_W, FRAME_H);
    send_query(0, 0, 0, 1);
    send_query(0, 0, 1, 0);
    send_query(FRAME_W - 1, 0, 2, 1);
    send_query(0, FRAME_H - 1, 1, 2);
    send_query(FRAME_W, 0, 1, 1);
    send_query(0, FRAME_H, 1, 1);
    send_query(0, 0, 10'h3ff, 8'hff);
  endtask

  task automatic test_match_bounds();
    send_write(100, 50, 24'h000000);
    send_write(101, 50, 24'hffffff);
    send_write(102, 50, 24'h0a141e);
    send_write(100, 51, 24'hc89664);
    send_write(101, 51, 24'hff0000);
    send_write(102, 51, 24'h0a141f);
    set_bounds(10, 10, 20, 20, 30, 30, 60, 60);
    send_query(100, 50, 3, 2);
    set_bounds(200, 100, 0, 255, 0, 255, 0, SUM_MAX);
    send_query(100, 50, 3, 2);
    set_bounds(0, 255, 0, 255, 0, 255, SUM_MAX, SUM_MAX);
    send_query(100, 50, 3, 2);
    set_bounds(0, 255, 0, 255, 0, 255, 0, 0);
    send_query(100, 50, 3, 2);
    set_bounds(255, 255, 0, 0, 0, 0, 255, 255);
    send_query(100, 50, 3, 2);
    set_bounds(0, 255, 0, 255, 0, 255, 0, SUM_MAX);
    send_query(100, 50, 3, 2);
  endtask

  task automatic test_random_traffic(input int count, input int unsigned tx_pct, rx_pct);
    bit [7:0] lo [3];
    bit [7:0] hi [3];
    for (int c = 0; c < 3; c++) begin
      lo[c] = $urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(200));
      hi[c] = $urandom_range(3) == 0 ? 8'd255 : 8'($urandom_range(55, 255));
    end
    set_bounds(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
               $urandom_range(3) == 0 ? 10'd0 : 10'($urandom_range(300)),
               $urandom_range(3) == 0 ? SUM_MAX : 10'($urandom_range(300, 765)));
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_item(random_item());
  endtask

  task automatic test_output_backpressure();
    wait_results_drained();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_left <= 600;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) begin
        send_query(10'(i), 0, 4, 2);
      end else begin
        send_read(10'(i), 8'(i % 4));
      end
    end
    wait_results_drained();
  endtask

  task automatic test_sender_pause();
    tx_idle_pct = 0;
    rx_stall_pct = 30;
    repeat (3) begin
      repeat (6) send_item(random_item());
      wait_results_drained();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    foreach (frame_shadow[i]) frame_shadow[i] = '0;
    bound_shadow[REG_MIN_RED] = '0;
    bound_shadow[REG_MAX_RED] = 10'(CHAN_MAX);
    bound_shadow[REG_MIN_GREEN] = '0;
    bound_shadow[REG_MAX_GREEN] = 10'(CHAN_MAX);
    bound_shadow[REG_MIN_BLUE] = '0;
    bound_shadow[REG_MAX_BLUE] = 10'(CHAN_MAX);
    bound_shadow[REG_MIN_SUM] = '0;
    bound_shadow[REG_MAX_SUM] = SUM_MAX;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_cleared_frame();
    test_pixel_write_read();
    test_region_geometry();
    test_match_bounds();
    test_random_traffic(160, 0, 0);
    test_output_backpressure();
    test_random_traffic(160, 70, 0);
    test_sender_pause();
    test_random_traffic(160, 0, 70);
    test_random_traffic(160, 8, 8);

    wait_results_drained();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("region_color_match_signature_tb passed");
    end else begin
      $display("region_color_match_signature_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rcms_pkg.sv
hw/rtl/rcms_frame_ram.sv
hw/rtl/rcms_ctrl.sv
hw/rtl/rcms_dp.sv
hw/rtl/region_color_match_signature.sv
dv/region_color_match_signature_tb.sv
